@@ hdl/lsmp_pkg.sv @@
// Shared definitions for the LIFO stack with minimum and pair count unit.
// Holds the operation codes and the command bundle from controller to datapath.
// No dependencies.
package lsmp_pkg;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  typedef struct packed {
    logic load;   // capture the request and read the stack memories
    logic exec;   // carry out the operation and register the result
  } lsmp_cmd_t;

endpackage

@@ hdl/lsmp_ctrl.sv @@
// Controller of the stack unit: two-state sequencer for requests.
// Depends on lsmp_pkg for the command bundle.
module lsmp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_strobe,
  output lsmp_pkg::lsmp_cmd_t cmd
);
  import lsmp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   strobe_r;
  logic   strobe_nxt;

  assign busy       = (state_r == ST_EXEC);
  assign cmd.load   = start && (state_r == ST_IDLE);
  assign cmd.exec   = (state_r == ST_EXEC);
  assign out_strobe = strobe_r;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

endmodule

@@ hdl/lsmp_dpath.sv @@
// Datapath of the stack unit: stack and running-minimum memories, top-entry
// cache, counters and result registers. Depends on lsmp_pkg.
module lsmp_dpath #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lsmp_pkg::lsmp_cmd_t cmd,
  input  logic [1:0]          in_mode,
  input  logic signed [31:0]  in_value,
  output logic signed [31:0]  out_popped_value,
  output logic                out_was_empty,
  output logic                out_overflow,
  output logic [8:0]          out_depth,
  output logic [7:0]          out_equal_pairs,
  output logic                out_any_equal_pair,
  output logic signed [31:0]  out_min_value,
  output logic [7:0]          out_min_index
);
  import lsmp_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Memories: each entry holds its word and the minimum of it and all deeper
  // entries, with the bottom-based position of the deepest holder.
  logic signed [31:0] stack_mem   [STACK_DEPTH];
  logic signed [31:0] min_val_mem [STACK_DEPTH];
  logic [AW-1:0]      min_pos_mem [STACK_DEPTH];

  logic [1:0]         mode_r;
  logic signed [31:0] value_r;
  logic signed [31:0] rd_val_r;
  logic signed [31:0] rd_min_val_r;
  logic [AW-1:0]      rd_min_pos_r;

  // Cache of the top entry, valid while the stack is not empty.
  logic signed [31:0] top_val_r,     top_val_nxt;
  logic signed [31:0] top_min_val_r, top_min_val_nxt;
  logic [AW-1:0]      top_min_pos_r, top_min_pos_nxt;

  logic [CW-1:0]      top_count_r, top_count_nxt;
  logic [CW-1:0]      pair_count_r, pair_count_nxt;

  logic signed [31:0] popped_nxt;
  logic               empty_nxt;
  logic               over_nxt;
  logic               do_write;
  logic               full;
  logic               keep_below;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      idx_nxt;
  logic [31:0]        depth_w;
  logic [31:0]        pair_w;
  logic [31:0]        idx_w;

  logic signed [31:0] out_popped_value_r;
  logic               out_was_empty_r;
  logic               out_overflow_r;
  logic [8:0]         out_depth_r;
  logic [7:0]         out_equal_pairs_r;
  logic               out_any_equal_pair_r;
  logic signed [31:0] out_min_value_r;
  logic [7:0]         out_min_index_r;

  // A pop needs the entry just under the top, which becomes the new top.
  assign rd_addr    = AW'(top_count_r - CW'(2));
  assign wr_addr    = top_count_r[AW-1:0];
  assign full       = (top_count_r == CW'(STACK_DEPTH));
  assign keep_below = !(value_r < top_min_val_r);

  always_comb begin
    top_count_nxt   = top_count_r;
    pair_count_nxt  = pair_count_r;
    top_val_nxt     = top_val_r;
    top_min_val_nxt = top_min_val_r;
    top_min_pos_nxt = top_min_pos_r;
    popped_nxt      = '0;
    empty_nxt       = 1'b0;
    over_nxt        = 1'b0;
    do_write        = 1'b0;
    unique case (mode_r)
      MODE_PUSH: begin
        if (full) begin
          over_nxt = 1'b1;
        end else begin
          do_write        = 1'b1;
          top_val_nxt     = value_r;
          top_min_val_nxt = value_r;
          top_min_pos_nxt = wr_addr;
          if (top_count_r != '0) begin
            if (top_val_r == value_r) begin
              pair_count_nxt = pair_count_r + CW'(1);
            end
            if (keep_below) begin
              top_min_val_nxt = top_min_val_r;
              top_min_pos_nxt = top_min_pos_r;
            end
          end
          top_count_nxt = top_count_r + CW'(1);
        end
      end
      MODE_POP: begin
        if (top_count_r == '0) begin
          empty_nxt = 1'b1;
        end else begin
          popped_nxt    = top_val_r;
          top_count_nxt = top_count_r - CW'(1);
          if (top_count_r > CW'(1)) begin
            if (rd_val_r == top_val_r && pair_count_r != '0) begin
              pair_count_nxt = pair_count_r - CW'(1);
            end
            top_val_nxt     = rd_val_r;
            top_min_val_nxt = rd_min_val_r;
            top_min_pos_nxt = rd_min_pos_r;
          end
        end
      end
      MODE_CLEAR: begin
        top_count_nxt  = '0;
        pair_count_nxt = '0;
      end
      MODE_QUERY: begin
        empty_nxt = (top_count_r == '0);
      end
      default: begin
        empty_nxt = 1'b0;
      end
    endcase
  end

  assign idx_nxt = AW'(top_count_nxt - CW'(1)) - top_min_pos_nxt;
  assign depth_w = 32'(top_count_nxt);
  assign pair_w  = 32'(pair_count_nxt);
  assign idx_w   = 32'(idx_nxt);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r       <= in_mode;
      value_r      <= in_value;
      rd_val_r     <= stack_mem[rd_addr];
      rd_min_val_r <= min_val_mem[rd_addr];
      rd_min_pos_r <= min_pos_mem[rd_addr];
    end
    if (cmd.exec && do_write) begin
      stack_mem[wr_addr]   <= value_r;
      min_val_mem[wr_addr] <= top_min_val_nxt;
      min_pos_mem[wr_addr] <= top_min_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      top_val_r            <= top_val_nxt;
      top_min_val_r        <= top_min_val_nxt;
      top_min_pos_r        <= top_min_pos_nxt;
      out_popped_value_r   <= popped_nxt;
      out_was_empty_r      <= empty_nxt;
      out_overflow_r       <= over_nxt;
      out_depth_r          <= depth_w[8:0];
      out_equal_pairs_r    <= (pair_w > 32'd255) ? 8'hFF : pair_w[7:0];
      out_any_equal_pair_r <= (pair_count_nxt != '0);
      out_min_value_r      <= (top_count_nxt != '0) ? top_min_val_nxt : 32'sd0;
      out_min_index_r      <= (top_count_nxt != '0) ? idx_w[7:0] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r  <= '0;
      pair_count_r <= '0;
    end else if (cmd.exec) begin
      top_count_r  <= top_count_nxt;
      pair_count_r <= pair_count_nxt;
    end
  end

  assign out_popped_value   = out_popped_value_r;
  assign out_was_empty      = out_was_empty_r;
  assign out_overflow       = out_overflow_r;
  assign out_depth          = out_depth_r;
  assign out_equal_pairs    = out_equal_pairs_r;
  assign out_any_equal_pair = out_any_equal_pair_r;
  assign out_min_value      = out_min_value_r;
  assign out_min_index      = out_min_index_r;

  // Adjacent equal pairs can never outnumber the gaps between entries.
  a_pairs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (pair_count_r == '0) || (pair_count_r < top_count_r))
    else $error("pair count exceeds entries held");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    top_count_r <= CW'(STACK_DEPTH))
    else $error("depth beyond stack size");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && mode_r == MODE_PUSH && !full) |=>
      (top_count_r == $past(top_count_r) + CW'(1)))
    else $error("accepted push did not grow the stack");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(top_count_r) && $stable(pair_count_r))
    else $error("counters moved outside an operation");

endmodule

@@ hdl/lifo_stack_with_min_and_pair_count_unit.sv @@
// Top level of the LIFO stack with minimum and pair count unit.
// Instantiates lsmp_ctrl and lsmp_dpath; depends on lsmp_pkg.
//
//  channel   handshake          fields
//  request   start / busy       in_mode, in_value
//  result    out_strobe         out_popped_value .. out_min_index
//
// A request is captured in ST_IDLE, where the entry under the top is read from
// the stack memories; ST_EXEC then updates state and registers the result.
// The result is shown for one cycle on out_strobe, during which the next
// request may already be taken, as a new request is taken whenever busy is low.
// Reset (synchronous, rst_n low) empties the stack; memory contents stay.
// The receiver cannot stall; busy is high only during the update cycle.
module lifo_stack_with_min_and_pair_count_unit #(
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_value,
  output logic               out_strobe,
  output logic signed [31:0] out_popped_value,
  output logic               out_was_empty,
  output logic               out_overflow,
  output logic [8:0]         out_depth,
  output logic [7:0]         out_equal_pairs,
  output logic               out_any_equal_pair,
  output logic signed [31:0] out_min_value,
  output logic [7:0]         out_min_index
);
  import lsmp_pkg::*;

  lsmp_cmd_t cmd;

  lsmp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  lsmp_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_mode            (in_mode),
    .in_value           (in_value),
    .out_popped_value   (out_popped_value),
    .out_was_empty      (out_was_empty),
    .out_overflow       (out_overflow),
    .out_depth          (out_depth),
    .out_equal_pairs    (out_equal_pairs),
    .out_any_equal_pair (out_any_equal_pair),
    .out_min_value      (out_min_value),
    .out_min_index      (out_min_index)
  );

endmodule

@@ bench/tb_lifo_stack_with_min_and_pair_count_unit.sv @@
// Testbench for the LIFO stack with minimum and pair count unit.
// Drives stack requests with bursty timing and checks every result against a
// local prediction of the stack; depends on lsmp_pkg and the unit's top level.
module tb_lifo_stack_with_min_and_pair_count_unit;
  import lsmp_pkg::*;

  localparam int STACK_DEPTH = 256;
  localparam int IDLE_LIMIT  = 1000;

  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] value;
    bit                 drain;   // hold this request back until all results are in
  } stack_req_t;

  typedef struct {
    logic signed [31:0] popped;
    logic               was_empty;
    logic               overflow;
    logic [8:0]         depth;
    logic [7:0]         pairs;
    logic               any_pair;
    logic signed [31:0] min_val;
    logic [7:0]         min_idx;
  } stack_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_mode;
  logic signed [31:0] in_value;
  logic               out_strobe;
  logic signed [31:0] out_popped_value;
  logic               out_was_empty;
  logic               out_overflow;
  logic [8:0]         out_depth;
  logic [7:0]         out_equal_pairs;
  logic               out_any_equal_pair;
  logic signed [31:0] out_min_value;
  logic [7:0]         out_min_index;

  lifo_stack_with_min_and_pair_count_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .out_strobe        (out_strobe),
    .out_popped_value  (out_popped_value),
    .out_was_empty     (out_was_empty),
    .out_overflow      (out_overflow),
    .out_depth         (out_depth),
    .out_equal_pairs   (out_equal_pairs),
    .out_any_equal_pair(out_any_equal_pair),
    .out_min_value     (out_min_value),
    .out_min_index     (out_min_index)
  );

  // Local copy of the stack and its running statistics.
  logic signed [31:0] held_word [STACK_DEPTH];
  logic signed [31:0] low_word  [STACK_DEPTH];
  int                 low_pos   [STACK_DEPTH];
  int                 held_count;
  int                 pair_total;

  stack_req_t    req_queue[$];
  stack_result_t predicted_q[$];

  int total_reqs;
  int sent_count;
  int accepted_count;
  int results_seen;
  int errors;
  int gap_left;
  int burst_left;
  int idle_cycles;
  int overflow_hits;
  int empty_hits;
  int deepest;
  int most_pairs;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d: %s got 0x%08h want 0x%08h", results_seen, what, got, want);
    errors++;
  endtask

  function automatic stack_result_t apply_stack_op(input logic [1:0] mode,
                                                   input logic signed [31:0] word);
    stack_result_t      r;
    logic signed [31:0] mv;
    int                 mp;
    int                 below;
    r = '{default: '0};
    case (mode)
      MODE_PUSH: begin
        if (held_count >= STACK_DEPTH) begin
          r.overflow = 1'b1;
          overflow_hits++;
        end else begin
          mv = word;
          mp = held_count;
          if (held_count > 0) begin
            below = held_count - 1;
            if (held_word[below] == word) pair_total++;
            // An equal word does not displace the deeper minimum.
            if (!(word < low_word[below])) begin
              mv = low_word[below];
              mp = low_pos[below];
            end
          end
          held_word[held_count] = word;
          low_word[held_count]  = mv;
          low_pos[held_count]   = mp;
          held_count++;
        end
      end
      MODE_POP: begin
        if (held_count == 0) begin
          r.was_empty = 1'b1;
          empty_hits++;
        end else begin
          below = held_count - 1;
          r.popped = held_word[below];
          if (below > 0 && held_word[below - 1] == held_word[below] && pair_total > 0)
            pair_total--;
          held_count = below;
        end
      end
      MODE_CLEAR: begin
        held_count = 0;
        pair_total = 0;
      end
      default: begin
        if (held_count == 0) r.was_empty = 1'b1;
      end
    endcase
    if (held_count > 0) begin
      r.min_val = low_word[held_count - 1];
      r.min_idx = 8'(held_count - 1 - low_pos[held_count - 1]);
    end
    r.depth    = 9'(held_count);
    r.pairs    = (pair_total > 255) ? 8'd255 : 8'(pair_total);
    r.any_pair = (pair_total != 0);
    if (held_count > deepest) deepest = held_count;
    if (pair_total > most_pairs) most_pairs = pair_total;
    return r;
  endfunction

  task automatic add_req(input logic [1:0] mode, input logic signed [31:0] value,
                         input bit drain);
    stack_req_t q;
    q.mode  = mode;
    q.value = value;
    q.drain = drain;
    req_queue.push_back(q);
  endtask

  // Extremes, a narrow band of small values and random words, so that pairs and ties occur often.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5, 6: return 32'($urandom_range(0, 6)) - 32'sd3;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic add_fill(input bit same_word, input bit drain);
    logic signed [31:0] w;
    w = pick_word();
    add_req(MODE_CLEAR, $signed($urandom), drain);
    for (int i = 0; i < STACK_DEPTH; i++)
      add_req(MODE_PUSH, same_word ? w : pick_word(), 1'b0);
    for (int i = 0; i < 3; i++) add_req(MODE_PUSH, pick_word(), 1'b0);
    add_req(MODE_QUERY, $signed($urandom), 1'b0);
  endtask

  task automatic build_stimulus();
    int                 kind;
    int                 len;
    int                 push_pct;
    int                 random_count;
    logic signed [31:0] w;
    // Directed part: empty stack cases, extremes, pairs and ties for the minimum.
    add_req(MODE_QUERY, 32'sd0, 1'b0);
    add_req(MODE_POP, 32'sh7FFF_FFFF, 1'b0);
    add_req(MODE_PUSH, 32'sh8000_0000, 1'b0);
    add_req(MODE_PUSH, 32'sh8000_0000, 1'b0);
    add_req(MODE_PUSH, 32'sh7FFF_FFFF, 1'b0);
    add_req(MODE_PUSH, 32'sh7FFF_FFFF, 1'b0);
    add_req(MODE_PUSH, 32'sd5, 1'b0);
    add_req(MODE_QUERY, -32'sd1, 1'b0);
    add_req(MODE_POP, 32'sd0, 1'b0);
    add_req(MODE_POP, 32'sd0, 1'b0);
    add_req(MODE_POP, 32'sd0, 1'b0);
    add_req(MODE_POP, 32'sd0, 1'b0);
    add_req(MODE_PUSH, 32'sd0, 1'b0);
    add_req(MODE_PUSH, -32'sd1, 1'b0);
    add_req(MODE_PUSH, -32'sd1, 1'b0);
    add_req(MODE_PUSH, -32'sd1, 1'b0);
    add_req(MODE_PUSH, 32'sh8000_0000, 1'b0);
    add_req(MODE_QUERY, 32'sh5555_5555, 1'b0);
    add_req(MODE_CLEAR, 32'shAAAA_AAAA, 1'b0);
    add_req(MODE_QUERY, 32'sd0, 1'b0);
    add_req(MODE_POP, 32'sd0, 1'b0);
    add_req(MODE_PUSH, 32'sd7, 1'b0);
    add_req(MODE_PUSH, 32'sd7, 1'b0);
    add_req(MODE_CLEAR, 32'sd0, 1'b0);

    // Random part: a full stack of one word (pair count reaches its top), then
    // segments of varied character, with a second full stack of mixed words.
    random_count = 0;
    add_fill(1'b1, 1'b1);
    random_count += STACK_DEPTH + 5;
    while (random_count < 1000) begin
      if (random_count > 500 && random_count < 560) begin
        add_fill(1'b0, 1'b0);
        random_count += STACK_DEPTH + 5;
      end
      kind = $urandom_range(0, 4);
      len  = $urandom_range(8, 40);
      case (kind)
        0:       push_pct = 85;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < len; i++) begin
        w = pick_word();
        if (kind == 3 && i == 0) begin
          add_req(MODE_CLEAR, w, $urandom_range(0, 3) == 0);
        end else if (kind == 3) begin
          // Descending runs with repeats give ties for the minimum.
          add_req(MODE_PUSH, 32'sd20 - 32'(i / 2), 1'b0);
        end else if (kind == 4) begin
          add_req(2'($urandom_range(0, 3)), $signed($urandom), i == 0 && $urandom_range(0, 1));
        end else if ($urandom_range(1, 100) <= push_pct) begin
          add_req(MODE_PUSH, w, 1'b0);
        end else begin
          add_req(($urandom_range(0, 5) == 0) ? MODE_QUERY : MODE_POP, w, 1'b0);
        end
      end
      random_count += len;
    end
    total_reqs = req_queue.size();
  endtask

  // Driver: presents requests at the falling edge, in bursts with gaps between.
  always @(negedge clk) begin : drv
    stack_req_t nxt;
    if (rst_n && !(start && accepted_count != sent_count)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (req_queue.size() > 0 &&
                   !(req_queue[0].drain && predicted_q.size() != 0)) begin
        nxt = req_queue.pop_front();
        in_mode  <= nxt.mode;
        in_value <= nxt.value;
        start    <= 1'b1;
        sent_count++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, then records
  // any request taken at the same edge.
  always @(posedge clk) begin : mon
    stack_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("result with no request waiting, depth", 32'(out_depth), 32'd0);
        end else begin
          want = predicted_q.pop_front();
          if (out_popped_value !== want.popped)
            report_mismatch("popped_value", out_popped_value, want.popped);
          if (out_was_empty !== want.was_empty)
            report_mismatch("was_empty", 32'(out_was_empty), 32'(want.was_empty));
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", 32'(out_overflow), 32'(want.overflow));
          if (out_depth !== want.depth)
            report_mismatch("depth", 32'(out_depth), 32'(want.depth));
          if (out_equal_pairs !== want.pairs)
            report_mismatch("equal_pairs", 32'(out_equal_pairs), 32'(want.pairs));
          if (out_any_equal_pair !== want.any_pair)
            report_mismatch("any_equal_pair", 32'(out_any_equal_pair), 32'(want.any_pair));
          if (out_min_value !== want.min_val)
            report_mismatch("min_value", out_min_value, want.min_val);
          if (out_min_index !== want.min_idx)
            report_mismatch("min_index", 32'(out_min_index), 32'(want.min_idx));
        end
        results_seen++;
      end
      if (start && !busy) begin
        predicted_q.push_back(apply_stack_op(in_mode, in_value));
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // Watchdog on cycles in which neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst_n && !(start && !busy) && !out_strobe) idle_cycles <= idle_cycles + 1;
    else idle_cycles <= 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d of %0d requests taken",
               idle_cycles, accepted_count, total_reqs);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = MODE_QUERY;
    in_value       = '0;
    held_count     = 0;
    pair_total     = 0;
    sent_count     = 0;
    accepted_count = 0;
    results_seen   = 0;
    errors         = 0;
    gap_left       = 0;
    burst_left     = 1;
    idle_cycles    = 0;
    overflow_hits  = 0;
    empty_hits     = 0;
    deepest        = 0;
    most_pairs     = 0;
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (accepted_count < total_reqs || predicted_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Ran %0d requests, %0d results checked: %0d dropped pushes, %0d empty pops,",
             total_reqs, results_seen, overflow_hits, empty_hits);
    $display("deepest stack %0d, most adjacent equal pairs %0d.", deepest, most_pairs);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
